>>> hdl/frcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fraction reduction package
// Shared widths, sequencer states, status codes and the handshake structs
// between the sequencer and the shared divide/multiply unit.
// ----------------------------------------------------------------------------
package frcd_pkg;

  // Default width of the value range checked for overflow.
  localparam int unsigned ValueWidthDef = 32;

  // Fixed field widths of the result ports.
  localparam int unsigned NumWidth = 32;
  localparam int unsigned DenWidth = 31;
  localparam int unsigned StatusWidth = 2;

  // Operation codes.
  localparam logic OpReduce = 1'b0;
  localparam logic OpCommon = 1'b1;

  // Status codes.
  localparam logic [StatusWidth-1:0] StatusOk = 2'd0;
  localparam logic [StatusWidth-1:0] StatusZeroDen = 2'd1;
  localparam logic [StatusWidth-1:0] StatusOverflow = 2'd2;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_GCD,
    S_DIV_N,
    S_DIV_D,
    S_DIV_Q,
    S_DIV_SA,
    S_MUL_L,
    S_MUL_A,
    S_MUL_B,
    S_OUT
  } frcd_state_e;

  // Request to the shared unit.
  typedef struct packed {
    logic start;
    logic mul;
  } frcd_req_t;

  // Response from the shared unit.
  typedef struct packed {
    logic busy;
    logic done;
  } frcd_rsp_t;

endpackage

>>> hdl/fraction_reduce_common_denominator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fraction reduction and common denominator
// Reduces a signed fraction by the Euclidean GCD, or brings two fractions onto
// their least common denominator, using one shared divide/multiply unit.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                      Beat
// command   in         start_i, busy_o                op, A and B fractions
// result    out        valid_o (one-cycle strobe)     A and B results, status
//
// Each divide or multiply is one pass through the shared unit: a start,
// MagWidth steps and a done pulse. An item takes one such pass per Euclid step,
// plus two (reduce) or up to five (common denominator) more. busy_o stays high
// from the accepted beat until the result strobe. Reset clears the sequencer
// and the strobe; the receiver cannot stall.
// ----------------------------------------------------------------------------
module fraction_reduce_common_denominator_top import frcd_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = ValueWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          op_i,
  input  logic signed [NumWidth-1:0]    a_num_i,
  input  logic signed [NumWidth-1:0]    a_den_i,
  input  logic signed [NumWidth-1:0]    b_num_i,
  input  logic signed [NumWidth-1:0]    b_den_i,
  output logic                          valid_o,
  output logic signed [NumWidth-1:0]    res_a_num_o,
  output logic [DenWidth-1:0]           res_a_den_o,
  output logic signed [NumWidth-1:0]    res_b_num_o,
  output logic [DenWidth-1:0]           res_b_den_o,
  output logic [StatusWidth-1:0]        status_o
);

  localparam int unsigned MagWidth = (VALUE_WIDTH > NumWidth) ? VALUE_WIDTH : NumWidth;
  localparam logic [MagWidth-1:0] MaxV =
    ({{(MagWidth-1){1'b0}}, 1'b1} << (VALUE_WIDTH - 1)) - 1'b1;

  frcd_state_e state_q, state_d;

  logic [MagWidth-1:0] an_q, ad_q, bn_q, bd_q;
  logic [MagWidth-1:0] x_q, y_q, q_q, sa_q;
  logic [MagWidth-1:0] ra_n_q, ra_d_q, rb_n_q, rb_d_q;
  logic                op_q, a_neg_q, b_neg_q, zden_q, ovf_q;

  logic                   accept;
  logic [NumWidth-1:0]    an_m, ad_m, bn_m, bd_m;
  frcd_req_t              req;
  frcd_rsp_t              rsp;
  logic [MagWidth-1:0]    opa, opb, quo, rem;
  logic [2*MagWidth-1:0]  prod;
  logic                   big;

  logic                   out_ovf;
  logic [StatusWidth-1:0] out_status;

  assign busy_o = (state_q != S_IDLE);
  assign accept = start_i && !busy_o;

  // Sign and magnitude of the incoming fields.
  assign an_m = a_num_i[NumWidth-1] ? (NumWidth'(0) - a_num_i) : a_num_i;
  assign ad_m = a_den_i[NumWidth-1] ? (NumWidth'(0) - a_den_i) : a_den_i;
  assign bn_m = b_num_i[NumWidth-1] ? (NumWidth'(0) - b_num_i) : b_num_i;
  assign bd_m = b_den_i[NumWidth-1] ? (NumWidth'(0) - b_den_i) : b_den_i;

  assign big = (prod > {{MagWidth{1'b0}}, MaxV});

  // Shared unit.
  frcd_alu #(
    .MagWidth(MagWidth)
  ) u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .a_i    (opa),
    .b_i    (opb),
    .rsp_o  (rsp),
    .quo_o  (quo),
    .rem_o  (rem),
    .prod_o (prod)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if ((ad_m == '0) || ((op_i == OpCommon) && (bd_m == '0))) begin
            state_d = S_OUT;
          end else if ((op_i == OpReduce) && (an_m == '0)) begin
            state_d = S_OUT;
          end else begin
            state_d = S_GCD;
          end
        end
      end
      S_GCD: begin
        if (y_q == '0) begin
          state_d = (op_q == OpCommon) ? S_DIV_Q : S_DIV_N;
        end
      end
      S_DIV_N:  if (rsp.done) state_d = S_DIV_D;
      S_DIV_D:  if (rsp.done) state_d = S_OUT;
      S_DIV_Q:  if (rsp.done) state_d = S_DIV_SA;
      S_DIV_SA: if (rsp.done) state_d = S_MUL_L;
      S_MUL_L:  if (rsp.done) state_d = big ? S_OUT : S_MUL_A;
      S_MUL_A:  if (rsp.done) state_d = big ? S_OUT : S_MUL_B;
      S_MUL_B:  if (rsp.done) state_d = S_OUT;
      S_OUT:    state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Unit requests and operand selection.
  always_comb begin
    req.start = 1'b0;
    req.mul   = 1'b0;
    opa       = x_q;
    opb       = y_q;
    unique case (state_q)
      S_GCD: begin
        req.start = (y_q != '0) && !rsp.busy && !rsp.done;
      end
      S_DIV_N: begin
        req.start = !rsp.busy && !rsp.done;
        opa       = an_q;
        opb       = x_q;
      end
      S_DIV_D, S_DIV_Q: begin
        req.start = !rsp.busy && !rsp.done;
        opa       = ad_q;
        opb       = x_q;
      end
      S_DIV_SA: begin
        req.start = !rsp.busy && !rsp.done;
        opa       = bd_q;
        opb       = x_q;
      end
      S_MUL_L: begin
        req.start = !rsp.busy && !rsp.done;
        req.mul   = 1'b1;
        opa       = q_q;
        opb       = bd_q;
      end
      S_MUL_A: begin
        req.start = !rsp.busy && !rsp.done;
        req.mul   = 1'b1;
        opa       = sa_q;
        opb       = an_q;
      end
      S_MUL_B: begin
        req.start = !rsp.busy && !rsp.done;
        req.mul   = 1'b1;
        opa       = q_q;
        opb       = bn_q;
      end
      default: begin
        req.start = 1'b0;
      end
    endcase
  end

  // Final status; zero denominator wins over overflow.
  assign out_ovf = ovf_q || (ra_n_q > MaxV) || (ra_d_q > MaxV);
  always_comb begin
    priority if (zden_q) begin
      out_status = StatusZeroDen;
    end else if (out_ovf) begin
      out_status = StatusOverflow;
    end else begin
      out_status = StatusOk;
    end
  end

  // Sequencer state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_q    <= op_i;
          an_q    <= MagWidth'(an_m);
          ad_q    <= MagWidth'(ad_m);
          bn_q    <= MagWidth'(bn_m);
          bd_q    <= MagWidth'(bd_m);
          a_neg_q <= (a_num_i[NumWidth-1] != a_den_i[NumWidth-1]) && (an_m != '0);
          b_neg_q <= (b_num_i[NumWidth-1] != b_den_i[NumWidth-1]) && (bn_m != '0);
          zden_q  <= (ad_m == '0) || ((op_i == OpCommon) && (bd_m == '0));
          x_q     <= MagWidth'(ad_m);
          y_q     <= (op_i == OpCommon) ? MagWidth'(bd_m) : MagWidth'(an_m);
          ra_n_q  <= MagWidth'(an_m);
          ra_d_q  <= MagWidth'(ad_m);
          rb_n_q  <= '0;
          rb_d_q  <= '0;
          ovf_q   <= 1'b0;
        end
      end
      S_GCD: begin
        if (rsp.done) begin
          x_q <= y_q;
          y_q <= rem;
        end
      end
      S_DIV_N:  if (rsp.done) ra_n_q <= quo;
      S_DIV_D:  if (rsp.done) ra_d_q <= quo;
      S_DIV_Q:  if (rsp.done) q_q <= quo;
      S_DIV_SA: if (rsp.done) sa_q <= quo;
      S_MUL_L: begin
        if (rsp.done) begin
          ovf_q  <= big;
          ra_d_q <= prod[MagWidth-1:0];
          rb_d_q <= prod[MagWidth-1:0];
        end
      end
      S_MUL_A: begin
        if (rsp.done) begin
          ovf_q  <= big;
          ra_n_q <= prod[MagWidth-1:0];
        end
      end
      S_MUL_B: begin
        if (rsp.done) begin
          ovf_q  <= big;
          rb_n_q <= prod[MagWidth-1:0];
        end
      end
      default: begin
        ovf_q <= ovf_q;
      end
    endcase
  end

  // Result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= (state_q == S_OUT);
    end
  end

  // Result beat; numeric fields are zero unless the status is ok.
  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT) begin
      status_o <= out_status;
      if (out_status == StatusOk) begin
        res_a_num_o <= a_neg_q ? (NumWidth'(0) - ra_n_q[NumWidth-1:0]) : ra_n_q[NumWidth-1:0];
        res_a_den_o <= ra_d_q[DenWidth-1:0];
        res_b_num_o <= b_neg_q ? (NumWidth'(0) - rb_n_q[NumWidth-1:0]) : rb_n_q[NumWidth-1:0];
        res_b_den_o <= rb_d_q[DenWidth-1:0];
      end else begin
        res_a_num_o <= '0;
        res_a_den_o <= '0;
        res_b_num_o <= '0;
        res_b_den_o <= '0;
      end
    end
  end

endmodule

>>> hdl/frcd_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared divide/multiply unit
// Radix-2 restoring divider and shift-add multiplier that share one adder.
// Takes one bit per cycle; done pulses for one cycle with the results held.
// ----------------------------------------------------------------------------
module frcd_alu import frcd_pkg::*; #(
  parameter int unsigned MagWidth = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  frcd_req_t               req_i,
  input  logic [MagWidth-1:0]     a_i,
  input  logic [MagWidth-1:0]     b_i,
  output frcd_rsp_t               rsp_o,
  output logic [MagWidth-1:0]     quo_o,
  output logic [MagWidth-1:0]     rem_o,
  output logic [2*MagWidth-1:0]   prod_o
);

  localparam int unsigned CntWidth = $clog2(MagWidth + 1);

  logic [2*MagWidth-1:0] acc_q, acc_d;
  logic [MagWidth-1:0]   opd_q;
  logic [CntWidth-1:0]   cnt_q;
  logic                  busy_q, done_q, mul_q;

  logic [MagWidth-1:0]   hi, lo;
  logic [MagWidth:0]     part, sum;

  assign hi = acc_q[2*MagWidth-1:MagWidth];
  assign lo = acc_q[MagWidth-1:0];

  // One step: add for multiplication, trial subtract for division.
  always_comb begin
    part = mul_q ? {1'b0, hi} : {hi, lo[MagWidth-1]};
    sum  = mul_q ? (part + {1'b0, opd_q}) : (part - {1'b0, opd_q});
    if (mul_q) begin
      acc_d = lo[0] ? {sum, lo[MagWidth-1:1]} : {1'b0, hi, lo[MagWidth-1:1]};
    end else if (sum[MagWidth]) begin
      acc_d = {part[MagWidth-1:0], lo[MagWidth-2:0], 1'b0};
    end else begin
      acc_d = {sum[MagWidth-1:0], lo[MagWidth-2:0], 1'b1};
    end
  end

  // Control: counter and flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      mul_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start && !busy_q) begin
        busy_q <= 1'b1;
        mul_q  <= req_i.mul;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntWidth'(MagWidth - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Operand and accumulator registers.
  always_ff @(posedge clk_i) begin
    if (req_i.start && !busy_q) begin
      acc_q <= {{MagWidth{1'b0}}, (req_i.mul ? b_i : a_i)};
      opd_q <= req_i.mul ? a_i : b_i;
    end else if (busy_q) begin
      acc_q <= acc_d;
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign quo_o      = lo;
  assign rem_o      = hi;
  assign prod_o     = acc_q;

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fraction reduction testbench
// Drives reduce and common-denominator commands into the block and compares
// every result strobe with a predictor that works in sign and magnitude.
// Directed corner cases come first, then random phases at three sender idle rates.
// ----------------------------------------------------------------------------
module tb_top;
  import frcd_pkg::*;

  localparam longint unsigned MaxMag = (64'd1 << (ValueWidthDef - 1)) - 1;
  localparam int unsigned CycleLimit = 2000000;

  // One expected result beat.
  typedef struct {
    logic signed [NumWidth-1:0] a_num;
    logic [DenWidth-1:0]        a_den;
    logic signed [NumWidth-1:0] b_num;
    logic [DenWidth-1:0]        b_den;
    logic [StatusWidth-1:0]     status;
  } fraction_result_t;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       start_i;
  logic                       busy_o;
  logic                       op_i;
  logic signed [NumWidth-1:0] a_num_i, a_den_i, b_num_i, b_den_i;
  logic                       valid_o;
  logic signed [NumWidth-1:0] res_a_num_o, res_b_num_o;
  logic [DenWidth-1:0]        res_a_den_o, res_b_den_o;
  logic [StatusWidth-1:0]     status_o;

  fraction_result_t pending_results[$];
  int unsigned      error_count;
  int unsigned      cycle_count;
  int unsigned      idle_percent;
  int unsigned      results_seen;

  fraction_reduce_common_denominator_top uut (.*);

  // Clock generation.
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Magnitude of a two's complement field.
  function automatic longint unsigned magnitude(logic [NumWidth-1:0] x);
    return x[NumWidth-1] ? 64'h1_0000_0000 - x : {32'd0, x};
  endfunction

  function automatic longint unsigned euclid_gcd(longint unsigned x, longint unsigned y);
    longint unsigned t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  // Predicts the normalised fractions for one command beat.
  function automatic fraction_result_t predict_fractions(logic op, logic [31:0] an,
      logic [31:0] ad, logic [31:0] bn, logic [31:0] bd);
    fraction_result_t r;
    longint unsigned anm, adm, bnm, bdm, rn, rd, rbn, g, q, l, sa, sb;
    logic a_neg, b_neg;
    r = '{default: '0};
    anm = magnitude(an);
    adm = magnitude(ad);
    bnm = magnitude(bn);
    bdm = magnitude(bd);
    rn = 0;
    rd = 0;
    rbn = 0;
    if (adm == 0 || (op == OpCommon && bdm == 0)) begin
      r.status = StatusZeroDen;
      return r;
    end
    a_neg = (an[31] != ad[31]) && anm != 0;
    b_neg = (bn[31] != bd[31]) && bnm != 0;
    if (op == OpReduce) begin
      rn = anm;
      rd = adm;
      if (rn != 0) begin
        g = euclid_gcd(rd, rn);
        rn = rn / g;
        rd = rd / g;
      end
      if (rn > MaxMag || rd > MaxMag) r.status = StatusOverflow;
    end else begin
      g = euclid_gcd(adm, bdm);
      q = adm / g;
      if (q > MaxMag / bdm) begin
        r.status = StatusOverflow;
      end else begin
        l = q * bdm;
        sa = l / adm;
        sb = l / bdm;
        if ((anm != 0 && sa > MaxMag / anm) || (bnm != 0 && sb > MaxMag / bnm)) begin
          r.status = StatusOverflow;
        end else begin
          rn = sa * anm;
          rbn = sb * bnm;
          rd = l;
          r.b_den = l[DenWidth-1:0];
        end
      end
    end
    if (r.status != StatusOk) begin
      r.b_den = '0;
      return r;
    end
    r.a_num = a_neg ? -rn[31:0] : rn[31:0];
    r.a_den = rd[DenWidth-1:0];
    r.b_num = b_neg ? -rbn[31:0] : rbn[31:0];
    return r;
  endfunction

  // Sends one command beat, with an optional random gap first. Start stays
  // high after the accepting edge until a gap or the end of the phase drops it.
  task automatic send_command(logic op, logic [31:0] an, logic [31:0] ad,
      logic [31:0] bn, logic [31:0] bd);
    while ($urandom_range(99) < idle_percent) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    op_i    <= op;
    a_num_i <= an;
    a_den_i <= ad;
    b_num_i <= bn;
    b_den_i <= bd;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    pending_results.push_back(predict_fractions(op, an, ad, bn, bd));
  endtask

  // Mostly small values so that common factors are frequent.
  function automatic logic [31:0] random_value();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(64) * $urandom_range(64);
      2: return -($urandom_range(64) * $urandom_range(64));
      3: return $urandom_range(1000) - 500;
      4: return ($urandom_range(1, 255) << $urandom_range(23));
      default: return {1'b0, 31'($urandom)};
    endcase
  endfunction

  task automatic wait_for_results();
    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Corner cases: field extremes, zero denominators, overflow, signs.
  task automatic test_directed();
    idle_percent = 0;
    send_command(OpReduce, 32'sd6, 32'sd4, 32'sd0, 32'sd0);
    send_command(OpReduce, -32'sd6, -32'sd4, 32'sd0, 32'sd0);
    send_command(OpReduce, 32'sd6, -32'sd9, 32'sd0, 32'sd0);
    send_command(OpReduce, 32'sd0, -32'sd7, 32'sd0, 32'sd0);
    send_command(OpReduce, 32'sd5, 32'sd0, 32'sd0, 32'sd0);
    send_command(OpReduce, 32'h8000_0000, 32'sd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_command(OpReduce, 32'h8000_0000, 32'sd1, 32'sd0, 32'sd0);
    send_command(OpReduce, 32'sd1, 32'h8000_0000, 32'sd0, 32'sd0);
    send_command(OpReduce, 32'h7FFF_FFFF, 32'h8000_0001, 32'sd0, 32'sd0);
    send_command(OpReduce, 32'h8000_0000, 32'h8000_0000, 32'sd0, 32'sd0);
    send_command(OpCommon, 32'sd1, 32'sd2, 32'sd1, 32'sd3);
    send_command(OpCommon, -32'sd1, 32'sd4, 32'sd3, -32'sd6);
    send_command(OpCommon, 32'sd1, 32'sd0, 32'sd1, 32'sd3);
    send_command(OpCommon, 32'sd1, 32'sd3, 32'sd1, 32'sd0);
    send_command(OpCommon, 32'sd0, 32'sd5, 32'sd0, 32'sd7);
    send_command(OpCommon, 32'sd1, 32'd65537, 32'sd1, 32'd65539);
    send_command(OpCommon, 32'h7FFF_FFFF, 32'sd2, 32'sd1, 32'sd3);
    send_command(OpCommon, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0001, 32'h7FFF_FFFF);
    send_command(OpCommon, 32'h8000_0000, 32'sd1, 32'sd1, 32'sd1);
    send_command(OpCommon, 32'hFFFF_FFFF, 32'h8000_0000, 32'sd1, 32'h4000_0000);
    send_command(OpCommon, 32'sd3, 32'sd0, 32'sd0, 32'sd0);
    wait_for_results();
  endtask

  // Random commands with the sender idling at the given rate.
  task automatic test_random(int unsigned count, int unsigned idle);
    logic [31:0] ad, bd;
    idle_percent = idle;
    repeat (count) begin
      ad = random_value();
      bd = random_value();
      if ($urandom_range(30) != 0 && ad == 0) ad = 1;
      if ($urandom_range(30) != 0 && bd == 0) bd = 3;
      send_command(1'($urandom), random_value(), ad, random_value(), bd);
    end
    wait_for_results();
  endtask

  // Checks each result beat against the oldest expectation.
  always @(posedge clk_i) begin
    fraction_result_t exp_r;
    if (rst_ni && valid_o) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result beat with no expectation waiting");
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (res_a_num_o !== exp_r.a_num) begin
          $error("res_a_num expected %0d actual %0d", exp_r.a_num, res_a_num_o);
          error_count++;
        end
        if (res_a_den_o !== exp_r.a_den) begin
          $error("res_a_den expected %0d actual %0d", exp_r.a_den, res_a_den_o);
          error_count++;
        end
        if (res_b_num_o !== exp_r.b_num) begin
          $error("res_b_num expected %0d actual %0d", exp_r.b_num, res_b_num_o);
          error_count++;
        end
        if (res_b_den_o !== exp_r.b_den) begin
          $error("res_b_den expected %0d actual %0d", exp_r.b_den, res_b_den_o);
          error_count++;
        end
        if (status_o !== exp_r.status) begin
          $error("status expected %0d actual %0d", exp_r.status, status_o);
          error_count++;
        end
      end
    end
  end

  // Watchdog on the run length.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    error_count  = 0;
    cycle_count  = 0;
    results_seen = 0;
    idle_percent = 0;
    rst_ni  = 1'b0;
    start_i = 1'b0;
    op_i    = 1'b0;
    a_num_i = '0;
    a_den_i = '0;
    b_num_i = '0;
    b_den_i = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(120, 0);
    test_random(120, 67);
    test_random(110, 8);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      error_count++;
    end
    $display("Checked %0d result beats: directed corners plus random reduce and",
             results_seen);
    $display("common-denominator commands under three sender idle rates.");
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
